@@ design/hkv_pkg.sv @@
// Shared types and constants of the hashed key/value table.
// Used by hkv_cell, hkv_chain and hashed_key_value_table_unit; depends on nothing.
package hkv_pkg;

  localparam int Capacity   = 64;
  localparam int IdxW       = $clog2(Capacity);
  localparam int CountW     = $clog2(Capacity + 1);
  localparam int KeyW       = 64;
  localparam int ValueW     = 32;
  localparam int OrderW     = 32;
  localparam int OpW        = 2;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Word handed down the chain: the key under search and the running results.
  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic              hit;
    logic              free_seen;
    logic [ValueW-1:0] value;
    logic [OrderW-1:0] order;
  } probe_t;

  // Write command broadcast to every cell in the update cycle.
  typedef struct packed {
    logic              wr_new;
    logic              wr_val;
    logic              clr;
    logic [IdxW-1:0]   idx;
    logic [KeyW-1:0]   key;
    logic [ValueW-1:0] value;
    logic [OrderW-1:0] order;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_UPDATE = 3'b010,
    ST_OUT    = 3'b100
  } state_t;

endpackage

@@ design/hkv_cell.sv @@
// One entry of the table: valid bit, key, value and order tag.
// Compares its key with the passing probe; depends on hkv_pkg.
module hkv_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [hkv_pkg::IdxW-1:0] my_idx,
  input  hkv_pkg::cmd_t        cmd,
  output logic                 valid,
  output logic                 match,
  input  logic [hkv_pkg::KeyW-1:0] probe_key,
  output logic [hkv_pkg::ValueW-1:0] value,
  output logic [hkv_pkg::OrderW-1:0] order
);

  logic                        valid_r;
  logic [hkv_pkg::KeyW-1:0]    key_r;
  logic [hkv_pkg::ValueW-1:0]  value_r;
  logic [hkv_pkg::OrderW-1:0]  order_r;
  logic                        sel;

  assign sel   = (cmd.idx == my_idx);
  assign valid = valid_r;
  assign match = valid_r && (key_r == probe_key);
  assign value = value_r;
  assign order = order_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (sel && cmd.wr_new) begin
      valid_r <= 1'b1;
    end else if (sel && cmd.clr) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && cmd.wr_new) begin
      key_r   <= cmd.key;
      order_r <= cmd.order;
    end
    if (sel && (cmd.wr_new || cmd.wr_val)) begin
      value_r <= cmd.value;
    end
  end

endmodule

@@ design/hkv_chain.sv @@
// Row of table cells with the priority chain that picks the matching entry
// and the lowest free entry; depends on hkv_pkg and hkv_cell.
module hkv_chain (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hkv_pkg::cmd_t        cmd,
  input  logic [hkv_pkg::KeyW-1:0] probe_key,
  output logic                 hit,
  output logic [hkv_pkg::IdxW-1:0] hit_idx,
  output logic                 free_seen,
  output logic [hkv_pkg::IdxW-1:0] free_idx,
  output logic [hkv_pkg::ValueW-1:0] hit_value,
  output logic [hkv_pkg::OrderW-1:0] hit_order
);

  localparam int N = hkv_pkg::Capacity;

  logic [N-1:0] valid_v;
  logic [N-1:0] match_v;
  logic [hkv_pkg::ValueW-1:0] val_a [N];
  logic [hkv_pkg::OrderW-1:0] ord_a [N];

  for (genvar g = 0; g < N; g++) begin : g_cell
    hkv_cell u_cell (
      .clk(clk), .rst_n(rst_n),
      .my_idx(hkv_pkg::IdxW'(g)),
      .cmd(cmd),
      .valid(valid_v[g]),
      .match(match_v[g]),
      .probe_key(probe_key),
      .value(val_a[g]),
      .order(ord_a[g])
    );
  end

  // Keys are unique, so at most one match: or-reduce the selected payload.
  always_comb begin
    hit       = 1'b0;
    hit_idx   = '0;
    free_seen = 1'b0;
    free_idx  = '0;
    hit_value = '0;
    hit_order = '0;
    for (int i = 0; i < N; i++) begin
      if (match_v[i]) begin
        hit     = 1'b1;
        hit_idx = hkv_pkg::IdxW'(i);
      end
      hit_value = hit_value | (val_a[i] & {hkv_pkg::ValueW{match_v[i]}});
      hit_order = hit_order | (ord_a[i] & {hkv_pkg::OrderW{match_v[i]}});
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_v[i]) begin
        free_seen = 1'b1;
        free_idx  = hkv_pkg::IdxW'(i);
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) $onehot0(match_v))
    else $error("more than one entry holds the key");
  assert property (@(posedge clk) disable iff (!rst_n) (match_v & ~valid_v) == '0)
    else $error("match on a free entry");
  assert property (@(posedge clk) disable iff (!rst_n) hit |-> valid_v[hit_idx])
    else $error("hit index points at a free entry");

endmodule

@@ design/hashed_key_value_table_unit.sv @@
// Top level of the hashed key/value table: handshakes, sequencer and counters.
// Depends on hkv_pkg and hkv_chain.
//
// Usage: one input word on in_* carries an insert, remove or lookup; exactly
// one result word leaves on out_* for each. in_tdata packs, from bit 0 up:
// operation[1:0], key_hash[65:2], value_in[97:66], given_order[129:98],
// zero fill to 136 bits. out_tdata packs found[0], value_out[32:1],
// order_out[64:33], table_full[65], zero fill to 72 bits.
// Timing: a word is accepted in IDLE; the next cycle compares the key with
// every entry at once and writes at most one entry; the result is then
// registered and shown. The table loop (compare then update one entry) sets
// the pace: no new word is taken until the last one's update is done, and the
// next word may be accepted in the same cycle as the waiting result is taken.
// Reset clears all valid bits, the entry count and sets the order counter to
// 1; stored keys, values and tags are kept as they are and never read while
// invalid. When the receiver stalls, hold the result word and take no new
// word until the result register is free.
module hashed_key_value_table_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // operation, key_hash, value_in, given_order
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata   // found, value_out, order_out, table_full
);

  hkv_pkg::state_t state_r, state_nxt;

  logic [hkv_pkg::OpW-1:0]    op_r;
  logic [hkv_pkg::KeyW-1:0]   key_r;
  logic [hkv_pkg::ValueW-1:0] val_r;
  logic [hkv_pkg::OrderW-1:0] gord_r;
  logic [hkv_pkg::OrderW-1:0] next_order_r;
  logic [hkv_pkg::CountW-1:0] count_r;

  logic                       res_found_r, res_full_r, out_valid_r;
  logic [hkv_pkg::ValueW-1:0] res_value_r;
  logic [hkv_pkg::OrderW-1:0] res_order_r;

  logic hit, free_seen;
  logic [hkv_pkg::IdxW-1:0]   hit_idx, free_idx;
  logic [hkv_pkg::ValueW-1:0] hit_value;
  logic [hkv_pkg::OrderW-1:0] hit_order;
  hkv_pkg::cmd_t cmd;

  logic                       is_ins, is_rem, is_look, use_cnt;
  logic [hkv_pkg::OrderW-1:0] ins_order;
  logic                       in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_valid_r && out_tready;
  // Accept only in idle with the result register free or draining.
  assign in_tready = (state_r == hkv_pkg::ST_IDLE) && (!out_valid_r || out_tready);

  assign is_ins  = (op_r == hkv_pkg::OP_INSERT);
  assign is_rem  = (op_r == hkv_pkg::OP_REMOVE);
  assign is_look = (op_r == hkv_pkg::OP_LOOKUP);
  assign use_cnt = is_ins && (gord_r == '0);
  assign ins_order = use_cnt ? next_order_r : gord_r;

  always_comb begin
    cmd        = '0;
    cmd.key    = key_r;
    cmd.value  = val_r;
    cmd.order  = ins_order;
    cmd.idx    = hit ? hit_idx : free_idx;
    if (state_r == hkv_pkg::ST_UPDATE) begin
      cmd.wr_val = is_ins && hit;
      cmd.wr_new = is_ins && !hit && free_seen;
      cmd.clr    = is_rem && hit;
    end
  end

  hkv_chain u_chain (
    .clk(clk), .rst_n(rst_n),
    .cmd(cmd),
    .probe_key(key_r),
    .hit(hit), .hit_idx(hit_idx),
    .free_seen(free_seen), .free_idx(free_idx),
    .hit_value(hit_value), .hit_order(hit_order)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hkv_pkg::ST_IDLE:   if (in_acc) state_nxt = hkv_pkg::ST_UPDATE;
      hkv_pkg::ST_UPDATE: state_nxt = hkv_pkg::ST_IDLE;
      hkv_pkg::ST_OUT:    state_nxt = hkv_pkg::ST_IDLE;
      default:            state_nxt = hkv_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= hkv_pkg::ST_IDLE;
      next_order_r <= hkv_pkg::OrderW'(1);
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == hkv_pkg::ST_UPDATE) begin
        out_valid_r <= 1'b1;
        if (use_cnt) next_order_r <= next_order_r + 1'b1;
        if (cmd.wr_new) count_r <= count_r + 1'b1;
        else if (cmd.clr && count_r != '0) count_r <= count_r - 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the input word; hold the result until taken.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_tdata[1:0];
      key_r  <= in_tdata[65:2];
      val_r  <= in_tdata[97:66];
      gord_r <= in_tdata[129:98];
    end
    if (state_r == hkv_pkg::ST_UPDATE) begin
      res_found_r <= (is_ins || is_rem || is_look) && hit;
      res_value_r <= (is_look && hit) ? hit_value : '0;
      res_full_r  <= is_ins && !hit && !free_seen;
      if ((is_rem || is_look || is_ins) && hit) res_order_r <= hit_order;
      else if (is_ins && free_seen)             res_order_r <= ins_order;
      else                                      res_order_r <= '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, res_full_r, res_order_r, res_value_r, res_found_r};

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= hkv_pkg::CountW'(hkv_pkg::Capacity))
    else $error("entry count exceeds capacity");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == hkv_pkg::ST_UPDATE)
    else $error("accepted word not processed");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hkv_pkg::ST_UPDATE |=> out_valid_r)
    else $error("result not raised after update");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_new || cmd.clr || cmd.wr_val) |-> state_r == hkv_pkg::ST_UPDATE)
    else $error("table written outside update");

endmodule

@@ sim/tb.sv @@
// Self-checking bench for hashed_key_value_table_unit: drives insert, remove,
// lookup and unused-code words, predicts each result from its own copy of the
// table and compares. Depends on hkv_pkg and the table RTL.
`timescale 1ns / 100ps

module tb;

  typedef struct packed {
    logic [hkv_pkg::OrderW-1:0] order;
    logic [hkv_pkg::ValueW-1:0] value;
    logic [hkv_pkg::KeyW-1:0]   key;
    logic [hkv_pkg::OpW-1:0]    op;
  } req_t;

  typedef struct packed {
    logic                       full;
    logic [hkv_pkg::OrderW-1:0] order;
    logic [hkv_pkg::ValueW-1:0] value;
    logic                       found;
  } resp_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [71:0]  out_tdata;

  hashed_key_value_table_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // Table shadow
  logic                       tbl_valid [hkv_pkg::Capacity];
  logic [hkv_pkg::KeyW-1:0]   tbl_key   [hkv_pkg::Capacity];
  logic [hkv_pkg::ValueW-1:0] tbl_value [hkv_pkg::Capacity];
  logic [hkv_pkg::OrderW-1:0] tbl_order [hkv_pkg::Capacity];
  logic [hkv_pkg::OrderW-1:0] order_ctr;

  req_t        pending_words[$];
  resp_t       expected_resps[$];
  logic [63:0] used_keys[$];
  int          errors = 0;
  int          cycles = 0;
  int          hold_off = 0;   // long receiver stall, in cycles

  // Apply one word to the shadow table and return the result it causes.
  function automatic resp_t table_step(req_t w);
    resp_t r;
    int hit, slot;
    logic [hkv_pkg::OrderW-1:0] ord;
    r = '0;
    hit = -1;
    slot = -1;
    ord = w.order;
    for (int i = 0; i < hkv_pkg::Capacity; i++)
      if (hit < 0 && tbl_valid[i] && tbl_key[i] == w.key) hit = i;
    case (hkv_pkg::op_t'(w.op))
      hkv_pkg::OP_INSERT: begin
        if (ord == '0) begin
          ord = order_ctr;
          order_ctr = order_ctr + 1;
        end
        if (hit >= 0) begin
          tbl_value[hit] = w.value;
          r.found = 1'b1;
          r.order = tbl_order[hit];
        end else begin
          for (int i = 0; i < hkv_pkg::Capacity; i++)
            if (slot < 0 && !tbl_valid[i]) slot = i;
          if (slot < 0) r.full = 1'b1;
          else begin
            tbl_valid[slot] = 1'b1;
            tbl_key[slot]   = w.key;
            tbl_value[slot] = w.value;
            tbl_order[slot] = ord;
            r.order = ord;
          end
        end
      end
      hkv_pkg::OP_REMOVE: if (hit >= 0) begin
        tbl_valid[hit] = 1'b0;
        r.found = 1'b1;
        r.order = tbl_order[hit];
      end
      hkv_pkg::OP_LOOKUP: if (hit >= 0) begin
        r.found = 1'b1;
        r.value = tbl_value[hit];
        r.order = tbl_order[hit];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int short_or_long_gap();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // Random key: mostly from a small pool so hits are common
  function automatic logic [63:0] pick_key();
    if (used_keys.size() > 0 && $urandom_range(0, 3) != 0)
      return used_keys[$urandom_range(0, used_keys.size() - 1)];
    return {$urandom, $urandom};
  endfunction

  function automatic req_t mk(hkv_pkg::op_t op, logic [63:0] k, logic [31:0] v,
                              logic [31:0] o);
    req_t w;
    w.op = op; w.key = k; w.value = v; w.order = o;
    return w;
  endfunction

  // Driver: advance through the pending words with random gaps
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_resps.push_back(table_step(req_t'(in_tdata[129:0])));
        void'(pending_words.pop_front());
        in_gap = short_or_long_gap();
      end else if (in_gap > 0) begin
        in_gap = in_gap - 1;
      end
      if (in_gap == 0 && pending_words.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {6'd0, pending_words[0]};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver stall: count it down
  always @(posedge clk) begin
    if (rst_n && hold_off > 0) hold_off = hold_off - 1;
  end

  // Monitor: compare every result word with the oldest expectation
  int out_gap = 0;
  always @(posedge clk) begin
    resp_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = resp_t'(out_tdata[65:0]);
        if (expected_resps.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          errors++;
        end else begin
          want = expected_resps.pop_front();
          if (got.found !== want.found)
            $display("%0t: found exp %0h got %0h", $time, want.found, got.found);
          if (got.value !== want.value)
            $display("%0t: value exp %0h got %0h", $time, want.value, got.value);
          if (got.order !== want.order)
            $display("%0t: order exp %0h got %0h", $time, want.order, got.order);
          if (got.full !== want.full)
            $display("%0t: full exp %0h got %0h", $time, want.full, got.full);
          if (got !== want) errors++;
        end
        out_gap = short_or_long_gap();
      end
      if (hold_off > 0) begin
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap = out_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > 1000000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_words.size() > 0 || expected_resps.size() > 0 || in_tvalid)
      @(posedge clk);
  endtask

  initial begin
    logic [63:0] k;
    int op;
    for (int i = 0; i < hkv_pkg::Capacity; i++) tbl_valid[i] = 1'b0;
    order_ctr = 1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: misses on empty table, extremes, overwrite, remove, unused code
    pending_words.push_back(mk(hkv_pkg::OP_LOOKUP, 64'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_words.push_back(mk(hkv_pkg::OP_REMOVE, '1, 32'd0, 32'd0));
    pending_words.push_back(mk(hkv_pkg::OP_INSERT, 64'd0, 32'hFFFF_FFFF, 32'd0));
    pending_words.push_back(mk(hkv_pkg::OP_INSERT, '1, 32'd0, 32'hFFFF_FFFF));
    pending_words.push_back(mk(hkv_pkg::OP_INSERT, 64'd0, 32'h1234_5678, 32'd0));
    pending_words.push_back(mk(hkv_pkg::OP_LOOKUP, 64'd0, 32'd0, 32'd0));
    pending_words.push_back(mk(hkv_pkg::OP_LOOKUP, '1, 32'd0, 32'd0));
    pending_words.push_back(mk(hkv_pkg::OP_NONE, '1, '1, '1));
    pending_words.push_back(mk(hkv_pkg::OP_REMOVE, '1, 32'd0, 32'd0));
    pending_words.push_back(mk(hkv_pkg::OP_LOOKUP, '1, 32'd0, 32'd0));
    pending_words.push_back(mk(hkv_pkg::OP_REMOVE, 64'd0, 32'd0, 32'd0));
    // Pause the sender until every result has come
    wait_drained();

    // Fill the table, overflow it, overwrite while full, then empty it,
    // with the receiver held off so the block stalls its input
    hold_off = 300;
    for (int i = 0; i < hkv_pkg::Capacity + 4; i++)
      pending_words.push_back(mk(hkv_pkg::OP_INSERT, 64'hA5A5_0000_0000_0000 | i,
                                 $urandom, 32'd0));
    pending_words.push_back(mk(hkv_pkg::OP_INSERT, 64'hA5A5_0000_0000_0005,
                               32'hCAFE_F00D, 32'd7));
    for (int i = 0; i < hkv_pkg::Capacity; i++)
      pending_words.push_back(mk(hkv_pkg::OP_REMOVE, 64'hA5A5_0000_0000_0000 | i,
                                 32'd0, 32'd0));
    wait_drained();

    // Random part: keys reused to get hits; table churns around full
    for (int n = 0; n < 1600; n++) begin
      k = pick_key();
      if (used_keys.size() < 90) used_keys.push_back(k);
      op = $urandom_range(0, 15);
      pending_words.push_back(mk(op < 7 ? hkv_pkg::OP_INSERT :
                                 op < 11 ? hkv_pkg::OP_REMOVE :
                                 op < 15 ? hkv_pkg::OP_LOOKUP : hkv_pkg::OP_NONE,
                                 k, $urandom, ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom));
      if (pending_words.size() > 20) begin
        while (pending_words.size() >= 8) @(posedge clk);
      end
    end
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_resps.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
